FILE: src/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg: shared types and codes for the nearest point search block
// Item structs for both channels, operation codes and the control struct
// that the top level hands to the distance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

  // Operation codes carried in the request item
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned INDEX_W = 8;

  // One stored or query point
  typedef struct packed {
    logic signed [COORD_W-1:0] lat;
    logic signed [COORD_W-1:0] lon;
  } point_t;

  // Request item
  typedef struct packed {
    logic [1:0]                operation;
    logic signed [COORD_W-1:0] point_lat;
    logic signed [COORD_W-1:0] point_lon;
  } req_t;

  // Response item
  typedef struct packed {
    logic [INDEX_W-1:0] best_index;
    logic               found;
  } rsp_t;

  // Control from the scan sequencer to the distance unit
  typedef struct packed {
    logic start;  // new query: forget the running best
    logic valid;  // a stored point arrives from memory this cycle
  } dist_ctl_t;

endpackage

`default_nettype wire

FILE: src/nearest_point_search_top.sv
// ----------------------------------------------------------------------------
// nearest_point_search_top: nearest neighbor search, squared Euclidean
// Keeps up to MAX_POINTS signed 16-bit points in a memory; a query item
// scans them and returns the index of the nearest one.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   req     | in        | req_valid/req_ready  | operation, point_lat/lon
//   rsp     | out       | rsp_valid/rsp_ready  | best_index, found
//
// Clear and append items leave the block idle. A query with N > 0 stored
// points holds req_ready low while it makes N reads, drains the read register
// and the distance pipeline, sees it empty and loads the output register. An
// empty store skips the reads. Reset empties the store at once (no clearing
// pass). A stalled response holds in the output register; a second query
// waits for it before loading.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_point_search_top #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire nps_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output nps_pkg::rsp_t      rsp
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t             state;
  logic [CW-1:0]      point_count;
  nps_pkg::point_t    qry;
  logic [CW-1:0]      issue_idx;
  logic               rd_vld;
  logic [AW-1:0]      rd_idx;
  logic               found;

  logic               accept;
  logic               wr_en;
  logic               issuing;
  logic               rsp_load;
  logic               dist_busy;
  logic [AW-1:0]      best_idx;
  nps_pkg::point_t    wr_pt;
  nps_pkg::point_t    rd_pt;
  nps_pkg::dist_ctl_t dctl;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign wr_en     = accept && (req.operation == nps_pkg::OP_APPEND)
                     && (point_count < CW'(MAX_POINTS));
  assign issuing   = (state == S_SCAN) && (issue_idx < point_count);
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || rsp_ready);

  assign wr_pt.lat = req.point_lat;
  assign wr_pt.lon = req.point_lon;

  assign dctl.start = accept && (req.operation == nps_pkg::OP_QUERY);
  assign dctl.valid = rd_vld;

  nps_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (point_count[AW-1:0]),
    .wr_data (wr_pt),
    .rd_en   (issuing),
    .rd_addr (issue_idx[AW-1:0]),
    .rd_data (rd_pt)
  );

  nps_dist #(
    .AW (AW)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .ctl      (dctl),
    .idx      (rd_idx),
    .pt       (rd_pt),
    .qry      (qry),
    .busy     (dist_busy),
    .best_idx (best_idx)
  );

  // Read tag is registered, so it follows the address in the next cycle
  always_ff @(posedge clk) begin
    rd_idx <= issue_idx[AW-1:0];
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issuing;
    end
  end

  // Sequencer, point count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= '0;
      issue_idx   <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.operation)
              nps_pkg::OP_CLEAR: begin
                point_count <= '0;
              end
              nps_pkg::OP_APPEND: begin
                if (wr_en) begin
                  point_count <= point_count + CW'(1);
                end
              end
              nps_pkg::OP_QUERY: begin
                qry.lat   <= req.point_lat;
                qry.lon   <= req.point_lon;
                found     <= (point_count != '0);
                issue_idx <= '0;
                state     <= S_SCAN;
              end
              default: begin
                // unused code: no effect
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issuing) begin
            issue_idx <= issue_idx + CW'(1);
          end else if (!rd_vld && !dist_busy) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp.best_index <= nps_pkg::INDEX_W'(best_idx);
            rsp.found      <= found;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/nps_mem.sv
// ----------------------------------------------------------------------------
// nps_mem: point store
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire nps_pkg::point_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output nps_pkg::point_t      rd_data
);

  nps_pkg::point_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/nps_dist.sv
// ----------------------------------------------------------------------------
// nps_dist: squared distance pipeline and running minimum
// Stage 1 takes absolute coordinate differences, stage 2 squares them,
// stage 3 sums and keeps the lowest index with the smallest distance.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_dist #(
  parameter int unsigned AW = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire nps_pkg::dist_ctl_t ctl,
  input  wire logic [AW-1:0]      idx,
  input  wire nps_pkg::point_t    pt,
  input  wire nps_pkg::point_t    qry,
  output logic                    busy,
  output logic [AW-1:0]           best_idx
);

  localparam int unsigned CW = nps_pkg::COORD_W;

  logic signed [CW:0] dlat;
  logic signed [CW:0] dlon;
  logic [CW:0]        nlat;
  logic [CW:0]        nlon;

  // Stage registers
  logic              s1_vld;
  logic [AW-1:0]     s1_idx;
  logic [CW-1:0]     s1_alat;
  logic [CW-1:0]     s1_alon;
  logic              s2_vld;
  logic [AW-1:0]     s2_idx;
  logic [2*CW-1:0]   s2_sqlat;
  logic [2*CW-1:0]   s2_sqlon;
  logic [2*CW:0]     dsum;
  logic [2*CW:0]     best_d;
  logic              have_best;

  // Signed differences, one bit wider than a coordinate
  assign dlat = {pt.lat[CW-1], pt.lat} - {qry.lat[CW-1], qry.lat};
  assign dlon = {pt.lon[CW-1], pt.lon} - {qry.lon[CW-1], qry.lon};
  assign nlat = -dlat;
  assign nlon = -dlon;

  assign dsum = {1'b0, s2_sqlat} + {1'b0, s2_sqlon};
  assign busy = s1_vld | s2_vld;

  // Stage 1: magnitudes of the differences (fit in CW bits)
  always_ff @(posedge clk) begin
    s1_idx  <= idx;
    s1_alat <= dlat[CW] ? nlat[CW-1:0] : dlat[CW-1:0];
    s1_alon <= dlon[CW] ? nlon[CW-1:0] : dlon[CW-1:0];
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= ctl.valid;
    end
  end

  // Stage 2: squares
  always_ff @(posedge clk) begin
    s2_idx   <= s1_idx;
    s2_sqlat <= s1_alat * s1_alat;
    s2_sqlon <= s1_alon * s1_alon;
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  // Stage 3: running minimum, strict compare keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
      best_idx  <= '0;
    end else if (ctl.start) begin
      have_best <= 1'b0;
      best_idx  <= '0;
    end else if (s2_vld && (!have_best || dsum < best_d)) begin
      have_best <= 1'b1;
      best_idx  <= s2_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld && (!have_best || dsum < best_d)) begin
      best_d <= dsum;
    end
  end

endmodule

`default_nettype wire

FILE: src/nps_checker.sv
// ----------------------------------------------------------------------------
// nps_checker: port-level checks for the nearest point search block
// Watches handshakes and response fields over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire nps_pkg::req_t req,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire nps_pkg::rsp_t rsp
);

  // A stalled response item holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response item changed or dropped while stalled");

  // A query occupies the block: no item is taken in the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.operation == nps_pkg::OP_QUERY |=> !req_ready)
    else $error("item accepted right after a query");

  // Empty store reports index zero
  a_empty_index: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.best_index == '0)
    else $error("nonzero index with found low");

  // Reset leaves the block ready with no pending response
  a_reset_state: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("response pending or not ready after reset");

endmodule

bind nearest_point_search_top nps_checker u_nps_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire
